### design/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation pipeline.
package bsc_pkg;

    // Field widths
    localparam int RawW    = 20;
    localparam int CfgIdxW = 2;

    // Divider depth: one quotient bit per stage
    localparam int DivSteps = 64;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_TEMP_GROUP    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_GROUP_A = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_GROUP_B = 2'd2;

    // Compensation constants
    localparam logic signed [32:0] FineOffset  = 33'sd128000;
    localparam logic [20:0]        PressBase   = 21'd1048576;
    localparam logic [11:0]        PressScale  = 12'd3125;
    localparam logic [63:0]        V1Bias      = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        TempRound   = 32'd128;
    localparam logic signed [31:0] TempMax     = 32'sd32767;
    localparam logic signed [31:0] TempMin     = -32'sd32768;
    localparam logic [17:0]        PressMax    = 18'h3FFFF;

    // Input transaction
    typedef struct packed {
        logic [RawW-1:0] raw_temperature;
        logic [RawW-1:0] raw_pressure;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [17:0]        pressure_pascal;
        logic               divide_fault;
    } t_out_item;

    // Unpacked calibration words
    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

    // Temperature section result
    typedef struct packed {
        logic signed [15:0] tc;
        logic signed [32:0] v1;
    } t_temp_res;

    // Pressure pre-division result
    typedef struct packed {
        logic signed [15:0] tc;
        logic [63:0]        num;
        logic signed [30:0] den;
    } t_pre_res;

    // Divider result
    typedef struct packed {
        logic signed [15:0] tc;
        logic [63:0]        quo;
        logic               fault;
    } t_div_res;

endpackage

### design/bsc_temp.sv
// Temperature compensation stages: fine temperature and centidegree output.
module bsc_temp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [bsc_pkg::RawW-1:0] i_raw_t,
    input  bsc_pkg::t_cal            i_cal,
    output logic                     o_valid,
    output bsc_pkg::t_temp_res       o_res
);

    logic [3:0] r_v;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end
    assign o_valid = r_v[3];

    // Stage 1: offsets and first products
    logic signed [17:0] a;
    logic signed [16:0] b;
    logic signed [33:0] m1;
    logic signed [33:0] bb;
    logic [31:0]        r_m1;
    logic [31:0]        r_sq;

    assign a  = $signed({1'b0, i_raw_t[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
    assign b  = $signed({1'b0, i_raw_t[19:4]}) - $signed({1'b0, i_cal.t1});
    assign m1 = a * i_cal.t2;
    assign bb = b * b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1 <= m1[31:0];
            r_sq <= bb[31:0];
        end
    end

    // Stage 2: first term and scaled square times T3
    logic signed [31:0] v1t;
    logic signed [31:0] sx;
    logic signed [35:0] m2;
    logic [31:0]        r_v1t;
    logic [31:0]        r_m2;

    assign v1t = $signed(r_m1) >>> 11;
    assign sx  = $signed(r_sq) >>> 12;
    assign m2  = $signed(sx[19:0]) * i_cal.t3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1t <= v1t;
            r_m2  <= m2[31:0];
        end
    end

    // Stage 3: fine temperature
    logic signed [31:0] v2t;
    logic [31:0]        r_fine;

    assign v2t = $signed(r_m2) >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fine <= r_v1t + v2t;
        end
    end

    // Stage 4: centidegrees with saturation, pressure offset term
    logic [31:0]        t5;
    logic signed [31:0] tc32;
    logic signed [15:0] tc_sat;

    assign t5   = r_fine + {r_fine[29:0], 2'b00} + bsc_pkg::TempRound;
    assign tc32 = $signed(t5) >>> 8;

    always_comb begin
        if (tc32 > bsc_pkg::TempMax) begin
            tc_sat = 16'sh7FFF;
        end else if (tc32 < bsc_pkg::TempMin) begin
            tc_sat = -16'sh8000;
        end else begin
            tc_sat = tc32[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.tc <= tc_sat;
            o_res.v1 <= $signed({r_fine[31], r_fine}) - bsc_pkg::FineOffset;
        end
    end

endmodule

### design/bsc_press_pre.sv
// Pressure stages ahead of the division: numerator and divisor.
module bsc_press_pre (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  bsc_pkg::t_temp_res       i_res,
    input  logic [bsc_pkg::RawW-1:0] i_raw_p,
    input  bsc_pkg::t_cal            i_cal,
    output logic                     o_valid,
    output bsc_pkg::t_pre_res        o_res
);

    logic [6:0] r_v;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end
    assign o_valid = r_v[6];

    // Stage 1: square and linear terms
    logic signed [65:0] sq66;
    logic signed [48:0] m5;
    logic signed [48:0] m2;
    logic [63:0]        r1_sq;
    logic [48:0]        r1_m5, r1_m2;
    logic [15:0]        r1_tc;
    logic [19:0]        r1_rp;

    assign sq66 = i_res.v1 * i_res.v1;
    assign m5   = i_res.v1 * i_cal.p5;
    assign m2   = i_res.v1 * i_cal.p2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sq <= sq66[63:0];
            r1_m5 <= m5;
            r1_m2 <= m2;
            r1_tc <= i_res.tc;
            r1_rp <= i_raw_p;
        end
    end

    // Stage 2: partial products of the square by P6 and P3
    logic signed [48:0] pl6, ph6f, pl3, ph3f;
    logic [48:0]        r2_pl6, r2_pl3, r2_m5, r2_m2;
    logic [31:0]        r2_ph6, r2_ph3;
    logic [15:0]        r2_tc;
    logic [19:0]        r2_rp;

    assign pl6  = $signed({1'b0, r1_sq[31:0]}) * i_cal.p6;
    assign ph6f = $signed({1'b0, r1_sq[63:32]}) * i_cal.p6;
    assign pl3  = $signed({1'b0, r1_sq[31:0]}) * i_cal.p3;
    assign ph3f = $signed({1'b0, r1_sq[63:32]}) * i_cal.p3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pl6 <= pl6;
            r2_ph6 <= ph6f[31:0];
            r2_pl3 <= pl3;
            r2_ph3 <= ph3f[31:0];
            r2_m5  <= r1_m5;
            r2_m2  <= r1_m2;
            r2_tc  <= r1_tc;
            r2_rp  <= r1_rp;
        end
    end

    // Stage 3: assemble products, base pressure term
    logic [63:0] r3_s6, r3_s3, r3_t5;
    logic [48:0] r3_m2;
    logic [20:0] r3_pb;
    logic [15:0] r3_tc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_s6 <= {{15{r2_pl6[48]}}, r2_pl6} + {r2_ph6, 32'b0};
            r3_s3 <= {{15{r2_pl3[48]}}, r2_pl3} + {r2_ph3, 32'b0};
            r3_t5 <= ({{15{r2_m5[48]}}, r2_m5} << 17)
                   + ({{48{i_cal.p4[15]}}, i_cal.p4} << 35);
            r3_m2 <= r2_m2;
            r3_pb <= bsc_pkg::PressBase - {1'b0, r2_rp};
            r3_tc <= r2_tc;
        end
    end

    // Stage 4: var2 and first part of var1
    logic signed [63:0] s3sh;
    logic [63:0]        r4_v2, r4_w;
    logic [20:0]        r4_pb;
    logic [15:0]        r4_tc;

    assign s3sh = $signed(r3_s3) >>> 8;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_v2 <= r3_s6 + r3_t5;
            r4_w  <= s3sh + ({{15{r3_m2[48]}}, r3_m2} << 12);
            r4_pb <= r3_pb;
            r4_tc <= r3_tc;
        end
    end

    // Stage 5: biased var1 and unscaled numerator
    logic [63:0] r5_x, r5_n;
    logic [15:0] r5_tc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_x  <= r4_w + bsc_pkg::V1Bias;
            r5_n  <= {12'b0, r4_pb, 31'b0} - r4_v2;
            r5_tc <= r4_tc;
        end
    end

    // Stage 6: partial products by P1 and by the pressure scale
    logic [47:0] xl, xhf;
    logic [43:0] nl, nhf;
    logic [47:0] r6_xl;
    logic [31:0] r6_xh, r6_nh;
    logic [43:0] r6_nl;
    logic [15:0] r6_tc;

    assign xl  = r5_x[31:0] * i_cal.p1;
    assign xhf = r5_x[63:32] * i_cal.p1;
    assign nl  = r5_n[31:0] * bsc_pkg::PressScale;
    assign nhf = r5_n[63:32] * bsc_pkg::PressScale;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_xl <= xl;
            r6_xh <= xhf[31:0];
            r6_nl <= nl;
            r6_nh <= nhf[31:0];
            r6_tc <= r5_tc;
        end
    end

    // Stage 7: divisor and numerator
    logic [63:0] y;

    assign y = {16'b0, r6_xl} + {r6_xh, 32'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.den <= y[63:33];
            o_res.num <= {20'b0, r6_nl} + {r6_nh, 32'b0};
            o_res.tc  <= r6_tc;
        end
    end

endmodule

### design/bsc_div.sv
// Pipelined signed 64 by 31-bit truncating divider, one quotient bit per stage.
module bsc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  bsc_pkg::t_pre_res i_res,
    output logic              o_valid,
    output bsc_pkg::t_div_res o_res
);

    logic [bsc_pkg::DivSteps+1:0] r_v;
    logic [63:0]      r_dvd [0:bsc_pkg::DivSteps];
    logic [30:0]      r_rem [0:bsc_pkg::DivSteps];
    logic [30:0]      r_da  [0:bsc_pkg::DivSteps];
    logic             r_neg [0:bsc_pkg::DivSteps];
    logic             r_flt [0:bsc_pkg::DivSteps];
    logic [15:0]      r_tc  [0:bsc_pkg::DivSteps];

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[bsc_pkg::DivSteps:0], i_valid};
        end
    end
    assign o_valid = r_v[bsc_pkg::DivSteps+1];

    // Entry: magnitudes, quotient sign, zero divisor check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd[0] <= i_res.num[63] ? (64'd0 - i_res.num) : i_res.num;
            r_da[0]  <= i_res.den[30] ? (31'd0 - i_res.den) : i_res.den;
            r_rem[0] <= '0;
            r_neg[0] <= i_res.num[63] ^ i_res.den[30];
            r_flt[0] <= (i_res.den == '0);
            r_tc[0]  <= i_res.tc;
        end
    end

    // Restoring steps; the dividend register fills with quotient bits
    for (genvar k = 1; k <= bsc_pkg::DivSteps; k++) begin : g_step
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        assign trial = {r_rem[k-1], r_dvd[k-1][63]};
        assign ge    = (trial >= {1'b0, r_da[k-1]});
        assign diff  = trial - {1'b0, r_da[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[30:0] : trial[30:0];
                r_dvd[k] <= {r_dvd[k-1][62:0], ge};
                r_da[k]  <= r_da[k-1];
                r_neg[k] <= r_neg[k-1];
                r_flt[k] <= r_flt[k-1];
                r_tc[k]  <= r_tc[k-1];
            end
        end
    end

    // Sign fix-up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.quo   <= r_neg[bsc_pkg::DivSteps] ? (64'd0 - r_dvd[bsc_pkg::DivSteps])
                                                    : r_dvd[bsc_pkg::DivSteps];
            o_res.fault <= r_flt[bsc_pkg::DivSteps];
            o_res.tc    <= r_tc[bsc_pkg::DivSteps];
        end
    end

endmodule

### design/bsc_press_post.sv
// Pressure stages after the division: correction terms and saturation.
module bsc_press_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  bsc_pkg::t_div_res  i_res,
    input  bsc_pkg::t_cal      i_cal,
    output logic               o_valid,
    output bsc_pkg::t_out_item o_res
);

    logic [6:0] r_v;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end
    assign o_valid = r_v[6];

    // Stage 1: partial products of ps squared and of p times P8
    logic signed [63:0] ps;
    logic [63:0]        pl, cf;
    logic signed [48:0] q8l, q8hf;
    logic [63:0]        r1_pl, r1_q;
    logic [31:0]        r1_c, r1_q8h;
    logic [48:0]        r1_q8l;
    logic [15:0]        r1_tc;
    logic               r1_f;

    assign ps   = $signed(i_res.quo) >>> 13;
    assign pl   = ps[31:0] * ps[31:0];
    assign cf   = ps[63:32] * ps[31:0];
    assign q8l  = $signed({1'b0, i_res.quo[31:0]}) * i_cal.p8;
    assign q8hf = $signed({1'b0, i_res.quo[63:32]}) * i_cal.p8;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pl  <= pl;
            r1_c   <= cf[31:0];
            r1_q8l <= q8l;
            r1_q8h <= q8hf[31:0];
            r1_q   <= i_res.quo;
            r1_tc  <= i_res.tc;
            r1_f   <= i_res.fault;
        end
    end

    // Stage 2: ps squared, var2
    logic [63:0] p8s;
    logic [63:0] r2_sq, r2_v2, r2_q;
    logic [15:0] r2_tc;
    logic        r2_f;

    assign p8s = {{15{r1_q8l[48]}}, r1_q8l} + {r1_q8h, 32'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sq <= r1_pl + {r1_c[30:0], 1'b0, 32'b0};
            r2_v2 <= $signed(p8s) >>> 19;
            r2_q  <= r1_q;
            r2_tc <= r1_tc;
            r2_f  <= r1_f;
        end
    end

    // Stage 3: partial products by P9
    logic signed [48:0] pl9, ph9f;
    logic [48:0]        r3_pl9;
    logic [31:0]        r3_ph9;
    logic [63:0]        r3_v2, r3_q;
    logic [15:0]        r3_tc;
    logic               r3_f;

    assign pl9  = $signed({1'b0, r2_sq[31:0]}) * i_cal.p9;
    assign ph9f = $signed({1'b0, r2_sq[63:32]}) * i_cal.p9;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pl9 <= pl9;
            r3_ph9 <= ph9f[31:0];
            r3_v2  <= r2_v2;
            r3_q   <= r2_q;
            r3_tc  <= r2_tc;
            r3_f   <= r2_f;
        end
    end

    // Stage 4: var1
    logic [63:0] p9s;
    logic [63:0] r4_v1, r4_v2, r4_q;
    logic [15:0] r4_tc;
    logic        r4_f;

    assign p9s = {{15{r3_pl9[48]}}, r3_pl9} + {r3_ph9, 32'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_v1 <= $signed(p9s) >>> 25;
            r4_v2 <= r3_v2;
            r4_q  <= r3_q;
            r4_tc <= r3_tc;
            r4_f  <= r3_f;
        end
    end

    // Stage 5: sum of corrections
    logic [63:0] r5_s;
    logic [15:0] r5_tc;
    logic        r5_f;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_s  <= r4_q + r4_v1 + r4_v2;
            r5_tc <= r4_tc;
            r5_f  <= r4_f;
        end
    end

    // Stage 6: Q24.8 pressure
    logic signed [63:0] s8;
    logic [63:0]        r6_p;
    logic [15:0]        r6_tc;
    logic               r6_f;

    assign s8 = $signed(r5_s) >>> 8;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_p  <= s8 + ({{48{i_cal.p7[15]}}, i_cal.p7} << 4);
            r6_tc <= r5_tc;
            r6_f  <= r5_f;
        end
    end

    // Stage 7: whole pascals, clamp, fault override
    logic [17:0] pa;

    always_comb begin
        if (r6_f || r6_p[63]) begin
            pa = '0;
        end else if (|r6_p[62:26]) begin
            pa = bsc_pkg::PressMax;
        end else begin
            pa = r6_p[25:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.temperature_centi <= r6_tc;
            o_res.pressure_pascal   <= pa;
            o_res.divide_fault      <= r6_f;
        end
    end

endmodule

### design/barometric_sensor_compensation_top.sv
// Top level of the barometric sensor compensation pipeline.
// One raw temperature/pressure pair is taken per cycle while o_stall is low and
// gives one result after 4 temperature stages, 7 pressure stages before the
// divide, a 66-stage divider (an entry stage, 64 stages that each resolve one
// quotient bit, a sign fix-up stage), 7 pressure stages after it and the output
// register. The divider sets the depth. An output register with a one-entry
// skid buffer decouples the two sides; input stall is registered and rises
// only when the skid entry is full. Calibration words are to be written through
// the configuration port while idle; the block itself does not enforce this.
module barometric_sensor_compensation_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  bsc_pkg::t_in_item           i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output bsc_pkg::t_out_item          o_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bsc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [63:0]                 i_cfg_data
);

    // Calibration registers
    logic [63:0] r_cal_t, r_cal_a, r_cal_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bsc_pkg::CFG_TEMP_GROUP:    r_cal_t <= i_cfg_data;
                bsc_pkg::CFG_PRESS_GROUP_A: r_cal_a <= i_cfg_data;
                bsc_pkg::CFG_PRESS_GROUP_B: r_cal_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Split into calibration words
    bsc_pkg::t_cal cal;

    assign cal.t1 = r_cal_t[15:0];
    assign cal.t2 = r_cal_t[31:16];
    assign cal.t3 = r_cal_t[47:32];
    assign cal.p1 = r_cal_t[63:48];
    assign cal.p2 = r_cal_a[15:0];
    assign cal.p3 = r_cal_a[31:16];
    assign cal.p4 = r_cal_a[47:32];
    assign cal.p5 = r_cal_a[63:48];
    assign cal.p6 = r_cal_b[15:0];
    assign cal.p7 = r_cal_b[31:16];
    assign cal.p8 = r_cal_b[47:32];
    assign cal.p9 = r_cal_b[63:48];

    // Pipeline advances whenever the skid entry is free
    logic r_out_v, r_skid_v;
    logic en;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    bsc_pkg::t_temp_res temp_res;
    bsc_pkg::t_pre_res  pre_res;
    bsc_pkg::t_div_res  div_res;
    bsc_pkg::t_out_item post_res;
    logic               temp_v, pre_v, div_v, post_v;

    bsc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_raw_t (i_data.raw_temperature),
        .i_cal   (cal),
        .o_valid (temp_v),
        .o_res   (temp_res)
    );

    // Raw pressure rides alongside the temperature stages
    logic [bsc_pkg::RawW-1:0] r_rp [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rp[0] <= i_data.raw_pressure;
            r_rp[1] <= r_rp[0];
            r_rp[2] <= r_rp[1];
            r_rp[3] <= r_rp[2];
        end
    end

    bsc_press_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (temp_v),
        .i_res   (temp_res),
        .i_raw_p (r_rp[3]),
        .i_cal   (cal),
        .o_valid (pre_v),
        .o_res   (pre_res)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pre_v),
        .i_res   (pre_res),
        .o_valid (div_v),
        .o_res   (div_res)
    );

    bsc_press_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_res   (div_res),
        .i_cal   (cal),
        .o_valid (post_v),
        .o_res   (post_res)
    );

    // Output register and skid entry
    bsc_pkg::t_out_item r_out_d, r_skid_d;
    logic               out_free;

    assign out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (out_free) begin
            r_out_v <= post_v;
        end else if (post_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_d <= r_skid_v ? r_skid_d : post_res;
        end
        if (!r_skid_v && !out_free && post_v) begin
            r_skid_d <= post_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out_d;

    // Skid entry is only held behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held with empty output register");

    // Skid fills only when the output transaction was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid filled without output stall");

    // Faulted results carry zero pressure
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.divide_fault) |-> (o_data.pressure_pascal == '0))
        else $error("fault result with nonzero pressure");

endmodule
